// ===== design/i2c_master_register_controller_core_assert.svh =====
// Assertion macros for the I2C master register controller.
`ifndef I2C_MASTER_REGISTER_CONTROLLER_CORE_ASSERT_SVH
`define I2C_MASTER_REGISTER_CONTROLLER_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define I2CM_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/i2cm_reg_pkg.sv =====
package i2cm_reg_pkg;

	localparam int unsigned FifoDepth = 2;

	typedef enum logic [3:0] {
		REG_CR1   = 4'd0,
		REG_CR2   = 4'd1,
		REG_OAR1  = 4'd2,
		REG_OAR2  = 4'd3,
		REG_DR    = 4'd4,
		REG_SR1   = 4'd5,
		REG_SR2   = 4'd6,
		REG_CCR   = 4'd7,
		REG_TRISE = 4'd8,
		REG_FLTR  = 4'd9
	} reg_idx_t;

	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_SEND  = 3'd2;
	localparam logic [2:0] ACT_RECV  = 3'd3;
	localparam logic [2:0] ACT_RSTOP = 3'd4;

	typedef struct packed {
		logic        wr;
		logic [3:0]  idx;
		logic [15:0] data;
		logic        ack;
		logic [7:0]  rx;
	} acc_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [2:0]  bus_action;
		logic [7:0]  bus_byte;
		logic        evt_irq;
		logic        err_irq;
	} res_t;

endpackage

// ===== design/i2cm_reg_front.sv =====
module i2cm_reg_front import i2cm_reg_pkg::*; #(
	parameter int unsigned DEPTH = FifoDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [3:0]  reg_index,
	input  logic [15:0] write_data,
	input  logic        slave_ack,
	input  logic [7:0]  rx_byte,
	output logic        acc_valid,
	input  logic        acc_take,
	output acc_t        acc
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	acc_t           mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;
	acc_t           in_w;
	logic           do_push, do_pop;

	always_comb begin
		in_w.wr   = cmd;
		in_w.idx  = reg_index;
		in_w.data = write_data;
		in_w.ack  = slave_ack;
		in_w.rx   = rx_byte;
	end

	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign acc_valid = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = acc_valid && acc_take;
	assign acc       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= in_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

// ===== design/i2cm_reg_back.sv =====
module i2cm_reg_back import i2cm_reg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic acc_valid,
	output logic acc_take,
	input  acc_t acc,
	output logic empty,
	input  logic pop,
	output res_t res
);

	typedef enum logic [2:0] {
		PH_DIS   = 3'd0,
		PH_IDLE  = 3'd1,
		PH_START = 3'd2,
		PH_AWR   = 3'd3,
		PH_ARD   = 3'd4,
		PH_TX    = 3'd5,
		PH_RX    = 3'd6
	} phase_t;

	logic [15:0] cr1_q, cr2_q, oar1_q, oar2_q, sr1_q, sr2_q, ccr_q;
	logic [7:0]  dr_q, tgt_q;
	logic [5:0]  trise_q;
	logic [4:0]  fltr_q;
	phase_t      ph_q;
	logic        sseen_q, stopp_q, aseen_q;
	logic        res_valid_q;

	logic [15:0] cr1, cr2, oar1, oar2, sr1, sr2, ccr, rd, v;
	logic [7:0]  dr, tgt;
	logic [5:0]  trise;
	logic [4:0]  fltr;
	phase_t      ph;
	logic [2:0]  act;
	logic [7:0]  abyte;
	logic        sseen, stopp, aseen, done, swrst, ev, er;

	assign acc_take = acc_valid && (!res_valid_q || pop);
	assign empty    = !res_valid_q;

	always_comb begin
		cr1 = cr1_q; cr2 = cr2_q; oar1 = oar1_q; oar2 = oar2_q; sr1 = sr1_q;
		sr2 = sr2_q; ccr = ccr_q; dr = dr_q; tgt = tgt_q; trise = trise_q;
		fltr = fltr_q; ph = ph_q; sseen = sseen_q; stopp = stopp_q; aseen = aseen_q;
		rd = '0; act = ACT_NONE; abyte = '0; done = 1'b0; swrst = 1'b0;
		v = acc.data;
		if (acc.wr) begin
			unique case (acc.idx)
				REG_CR1: begin
					if (cr1[0] != v[0]) begin
						if (v[0]) begin
							cr1[0] = 1'b1; ph = PH_IDLE;
						end else begin
							cr1[0] = 1'b0; sr1 = '0; sr2[0] = 1'b0; ph = PH_DIS;
						end
					end
					if (v[8]) begin
						if (!cr1[0]) done = 1'b1;
						else begin
							if (ph == PH_IDLE || ph == PH_TX || sr2[1]) begin
								sr2[1:0] = 2'b11; sr1[0] = 1'b1; sr1[2] = 1'b1;
								sr1[7] = 1'b0; ph = PH_START;
							end
							v[8] = 1'b0;
						end
					end
					if (!done && v[9]) begin
						if (!cr1[0]) done = 1'b1;
						else begin
							stopp = 1'b1;
							if ((ph == PH_AWR || ph == PH_TX) && !cr1[10]) begin
								sr2[1:0] = 2'b00; sr1[2] = 1'b0; sr1[7] = 1'b0;
								ph = PH_IDLE; sseen = 1'b0; stopp = 1'b0; aseen = 1'b0;
							end
							v[9] = 1'b0;
						end
					end
					if (!done && !cr1[0] && (cr1[10] != v[10] || cr1[11] != v[11]))
						done = 1'b1;
					if (!done && v[15]) swrst = 1'b1;
					else if (!done) cr1 = v;
				end
				REG_CR2:   cr2 = v;
				REG_OAR1:  oar1 = v;
				REG_OAR2:  oar2 = v;
				REG_DR: begin
					dr = v[7:0];
					sr1[2] = 1'b0; sr1[7] = 1'b0; sr1[6] = 1'b0;
					if (sr1[0] && sseen) begin
						sseen = 1'b0; sr1[0] = 1'b0;
					end
					if (ph == PH_START) begin
						act = ACT_START; abyte = dr;
						if (!acc.ack) sr1[10] = 1'b1;
						else begin
							tgt = {1'b0, dr[7:1]};
							sr2[2] = dr[0];
							sr1[1] = 1'b1; sr1[2] = 1'b1;
							if (dr[0]) begin
								sr1[6] = 1'b1; ph = PH_ARD;
							end else begin
								sr1[7] = 1'b1; ph = PH_AWR;
							end
							dr = '0;
						end
					end else if (ph == PH_AWR || ph == PH_TX) begin
						act = ACT_SEND; abyte = dr;
						if (acc.ack) begin
							sr1[7] = 1'b1; sr1[2] = 1'b1; dr = '0; ph = PH_TX;
						end
					end
				end
				REG_SR1:   sr1 = v;
				REG_CCR:   ccr = v;
				REG_TRISE: trise = v[5:0];
				REG_FLTR:  fltr = v[4:0];
				default: ;
			endcase
		end else begin
			if (acc.idx != REG_SR2) aseen = 1'b0;
			sseen = 1'b0;
			unique case (acc.idx)
				REG_CR1:  rd = cr1_q;
				REG_CR2:  rd = cr2_q;
				REG_OAR1: rd = oar1_q;
				REG_OAR2: rd = oar2_q;
				REG_DR: begin
					sr1[2] = 1'b0; sr1[6] = 1'b0;
					if (ph == PH_ARD || ph == PH_RX) begin
						if (!cr1[10] && stopp) begin
							act = ACT_RSTOP;
							sr2[1:0] = 2'b00; sr1[7] = 1'b0;
							ph = PH_IDLE; stopp = 1'b0; aseen = 1'b0;
						end else begin
							act = ACT_RECV; sr1[6] = 1'b1; sr1[2] = 1'b1; ph = PH_RX;
						end
						dr = acc.rx;
					end
					rd = {8'h00, dr};
				end
				REG_SR1: begin
					sseen = 1'b1; aseen = 1'b1; rd = sr1_q;
				end
				REG_SR2: begin
					if (aseen_q) begin
						aseen = 1'b0; sr1[1] = 1'b0;
					end
					rd = sr2_q;
				end
				REG_CCR:   rd = ccr_q;
				REG_TRISE: rd = {10'd0, trise_q};
				REG_FLTR:  rd = {11'd0, fltr_q};
				default:   rd = '0;
			endcase
		end
		if (swrst) begin
			cr1 = '0; cr2 = '0; oar1 = '0; oar2 = '0; dr = '0; sr1 = '0; sr2 = '0;
			ccr = '0; trise = 6'd2; fltr = '0; ph = PH_DIS; sseen = 1'b0;
			stopp = 1'b0; aseen = 1'b0; tgt = 8'hFF;
		end
		ev = cr2[9] && ((sr1[4:0] != '0) || (cr2[10] && (sr1[7:6] != '0)));
		er = cr2[8] && ((sr1 & 16'hDF00) != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr1_q <= '0; cr2_q <= '0; oar1_q <= '0; oar2_q <= '0; sr1_q <= '0;
			sr2_q <= '0; ccr_q <= '0; dr_q <= '0; tgt_q <= 8'hFF; trise_q <= 6'd2;
			fltr_q <= '0; ph_q <= PH_DIS; sseen_q <= 1'b0; stopp_q <= 1'b0;
			aseen_q <= 1'b0; res_valid_q <= 1'b0; res <= '0;
		end else begin
			// hold the result word until it is popped
			if (acc_take) begin
				cr1_q <= cr1; cr2_q <= cr2; oar1_q <= oar1; oar2_q <= oar2;
				sr1_q <= sr1; sr2_q <= sr2; ccr_q <= ccr; dr_q <= dr; tgt_q <= tgt;
				trise_q <= trise; fltr_q <= fltr; ph_q <= ph; sseen_q <= sseen;
				stopp_q <= stopp; aseen_q <= aseen;
				res_valid_q <= 1'b1;
				res.read_data  <= rd;
				res.bus_action <= act;
				res.bus_byte   <= abyte;
				res.evt_irq    <= ev;
				res.err_irq    <= er;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/i2c_master_register_controller_core.sv =====
// I2C master register controller.
// Input side is a queue: drive cmd, reg_index, write_data, slave_ack and
// rx_byte with push; a word is taken at a clock edge with push high and full
// low. Each access produces exactly one result word.
// Result side is a queue too: while empty is low the oldest result sits on
// read_data, bus_action, bus_byte, evt_irq and err_irq; pop takes it.
// A two-entry input queue feeds the register back end, which updates all
// registers combinationally and writes a one-word output register.
// A word taken into the input queue shows on the result ports once the back end
// has written its result into the output register. Throughput is one access
// per cycle while pop keeps up. When pop stays low the output register holds,
// the back end stalls and the input queue fills, then full rises.
// Reset (arst_n low) empties both queues and returns every register to its
// reset value: all zero except TRISE at 2, the target address at all ones,
// and the sequencer disabled.
module i2c_master_register_controller_core import i2cm_reg_pkg::*; #(
	parameter int unsigned DEPTH = FifoDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [3:0]  reg_index,
	input  logic [15:0] write_data,
	input  logic        slave_ack,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] read_data,
	output logic [2:0]  bus_action,
	output logic [7:0]  bus_byte,
	output logic        evt_irq,
	output logic        err_irq
);

	acc_t acc;
	res_t res;
	logic acc_valid, acc_take;

	i2cm_reg_front #(.DEPTH(DEPTH)) u_front (
		.clk, .arst_n, .push, .full, .cmd, .reg_index, .write_data,
		.slave_ack, .rx_byte, .acc_valid, .acc_take, .acc
	);

	i2cm_reg_back u_back (
		.clk, .arst_n, .acc_valid, .acc_take, .acc, .empty, .pop, .res
	);

	assign read_data  = res.read_data;
	assign bus_action = res.bus_action;
	assign bus_byte   = res.bus_byte;
	assign evt_irq    = res.evt_irq;
	assign err_irq    = res.err_irq;

endmodule

// ===== design/i2cm_reg_checker.sv =====
`include "i2c_master_register_controller_core_assert.svh"

module i2cm_reg_checker import i2cm_reg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  bus_action,
	input logic [7:0]  bus_byte,
	input logic [15:0] read_data
);

	logic shown, send_act, quiet_act;

	assign shown     = !empty;
	assign send_act  = (bus_action == ACT_START) || (bus_action == ACT_SEND);
	assign quiet_act = (bus_action == ACT_NONE) || (bus_action == ACT_RECV) ||
		(bus_action == ACT_RSTOP);

	`I2CM_ASSERT_IMPL(a_action_range, clk, arst_n, shown, send_act || quiet_act, "bad action")
	`I2CM_ASSERT_IMPL(a_byte_zero, clk, arst_n, shown && quiet_act, bus_byte == 8'd0, "byte set")
	`I2CM_ASSERT_IMPL(a_read_zero, clk, arst_n, shown && send_act, read_data == 16'd0, "write data")
	`I2CM_ASSERT_NEXT(a_hold, clk, arst_n, shown && !pop, shown && $stable(read_data), "dropped")

endmodule

bind i2c_master_register_controller_core i2cm_reg_checker u_checker (
	.clk, .arst_n, .empty, .pop, .bus_action, .bus_byte, .read_data
);

// ===== tb/i2c_master_register_controller_core_checker.sv =====
`timescale 1ns / 1ps
module i2c_master_register_controller_core_checker import i2cm_reg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        cmd,
	input  logic [3:0]  reg_index,
	input  logic [15:0] write_data,
	input  logic        slave_ack,
	input  logic [7:0]  rx_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [15:0] read_data,
	input  logic [2:0]  bus_action,
	input  logic [7:0]  bus_byte,
	input  logic        evt_irq,
	input  logic        err_irq,
	output int          errors,
	output int          pending
);
	localparam logic [2:0] PH_OFF = 3'd0, PH_IDLE = 3'd1, PH_START = 3'd2,
		PH_AWR = 3'd3, PH_ARD = 3'd4, PH_TX = 3'd5, PH_RX = 3'd6;
	localparam logic [15:0] CR1_PE = 16'h0001, CR1_START = 16'h0100, CR1_STOP = 16'h0200,
		CR1_ACK = 16'h0400, CR1_POS = 16'h0800, CR1_SWRST = 16'h8000;
	localparam logic [15:0] CR2_ERR = 16'h0100, CR2_EVT = 16'h0200, CR2_BUF = 16'h0400;
	localparam logic [15:0] SR1_SB = 16'h0001, SR1_ADDR = 16'h0002, SR1_BTF = 16'h0004,
		SR1_RXNE = 16'h0040, SR1_TXE = 16'h0080, SR1_AF = 16'h0400;
	localparam logic [15:0] SR2_MSL = 16'h0001, SR2_BUSY = 16'h0002, SR2_TRA = 16'h0004;

	logic [15:0] cr1, cr2, oar1, oar2, sr1, sr2, ccr;
	logic [7:0]  dr, target;
	logic [5:0]  trise;
	logic [4:0]  fltr;
	logic [2:0]  phase;
	logic        start_seen, stop_pend, addr_seen;
	res_t        expected_words[$];

	function automatic void clear_regs();
		cr1 = '0; cr2 = '0; oar1 = '0; oar2 = '0; sr1 = '0; sr2 = '0; ccr = '0;
		dr = '0; trise = 6'd2; fltr = '0; phase = PH_OFF;
		start_seen = 0; stop_pend = 0; addr_seen = 0; target = 8'hFF;
	endfunction

	function automatic void finish_transfer();
		sr2 &= ~(SR2_MSL | SR2_BUSY);
		sr1 &= ~(SR1_BTF | SR1_TXE);
		phase = PH_IDLE;
		start_seen = 0; stop_pend = 0; addr_seen = 0;
	endfunction

	function automatic void write_cr1(logic [15:0] v);
		if (cr1[0] != v[0]) begin
			if (v[0]) begin
				cr1 |= CR1_PE;
				phase = PH_IDLE;
			end else begin
				cr1 &= ~CR1_PE;
				sr1 = '0;
				sr2 &= ~SR2_MSL;
				phase = PH_OFF;
			end
		end
		if (v & CR1_START) begin
			if (!cr1[0]) return;
			if (phase == PH_IDLE || phase == PH_TX || (sr2 & SR2_BUSY)) begin
				sr2 |= SR2_MSL | SR2_BUSY;
				sr1 = (sr1 | SR1_SB | SR1_BTF) & ~SR1_TXE;
				phase = PH_START;
			end
			v &= ~CR1_START;
		end
		if (v & CR1_STOP) begin
			if (!cr1[0]) return;
			stop_pend = 1;
			if ((phase == PH_AWR || phase == PH_TX) && !(cr1 & CR1_ACK))
				finish_transfer();
			v &= ~CR1_STOP;
		end
		if ((cr1 & CR1_ACK) != (v & CR1_ACK) && !cr1[0]) return;
		if ((cr1 & CR1_POS) != (v & CR1_POS) && !cr1[0]) return;
		if (v & CR1_SWRST) begin
			clear_regs();
			return;
		end
		cr1 = v;
	endfunction

	function automatic res_t predict_access(logic wr, logic [3:0] idx, logic [15:0] v,
			logic ack, logic [7:0] rx);
		res_t r;
		r = '0;
		if (wr) begin
			case (idx)
				REG_CR1: write_cr1(v);
				REG_CR2: cr2 = v;
				REG_OAR1: oar1 = v;
				REG_OAR2: oar2 = v;
				REG_SR1: sr1 = v;
				REG_CCR: ccr = v;
				REG_TRISE: trise = v[5:0];
				REG_FLTR: fltr = v[4:0];
				REG_DR: begin
					dr = v[7:0];
					sr1 &= ~(SR1_BTF | SR1_TXE | SR1_RXNE);
					if ((sr1 & SR1_SB) && start_seen) begin
						start_seen = 0;
						sr1 &= ~SR1_SB;
					end
					if (phase == PH_START) begin
						r.bus_action = ACT_START;
						r.bus_byte = dr;
						if (!ack) sr1 |= SR1_AF;
						else begin
							target = {1'b0, dr[7:1]};
							if (dr[0]) sr2 |= SR2_TRA;
							else sr2 &= ~SR2_TRA;
							sr1 |= SR1_ADDR | SR1_BTF;
							if (dr[0]) begin
								sr1 |= SR1_RXNE;
								phase = PH_ARD;
							end else begin
								sr1 |= SR1_TXE;
								phase = PH_AWR;
							end
							dr = '0;
						end
					end else if (phase == PH_AWR || phase == PH_TX) begin
						r.bus_action = ACT_SEND;
						r.bus_byte = dr;
						if (ack) begin
							sr1 |= SR1_TXE | SR1_BTF;
							dr = '0;
							phase = PH_TX;
						end
					end
				end
				default: ;
			endcase
		end else begin
			if (addr_seen && idx != REG_SR2) addr_seen = 0;
			start_seen = 0;
			case (idx)
				REG_CR1: r.read_data = cr1;
				REG_CR2: r.read_data = cr2;
				REG_OAR1: r.read_data = oar1;
				REG_OAR2: r.read_data = oar2;
				REG_DR: begin
					sr1 &= ~(SR1_BTF | SR1_RXNE);
					if (phase == PH_ARD || phase == PH_RX) begin
						if (!(cr1 & CR1_ACK) && stop_pend) begin
							r.bus_action = ACT_RSTOP;
							finish_transfer();
						end else begin
							r.bus_action = ACT_RECV;
							sr1 |= SR1_RXNE | SR1_BTF;
							phase = PH_RX;
						end
						dr = rx;
					end
					r.read_data = {8'd0, dr};
				end
				REG_SR1: begin
					start_seen = 1;
					addr_seen = 1;
					r.read_data = sr1;
				end
				REG_SR2: begin
					if (addr_seen) begin
						addr_seen = 0;
						sr1 &= ~SR1_ADDR;
					end
					r.read_data = sr2;
				end
				REG_CCR: r.read_data = ccr;
				REG_TRISE: r.read_data = {10'd0, trise};
				REG_FLTR: r.read_data = {11'd0, fltr};
				default: r.read_data = '0;
			endcase
		end
		r.evt_irq = (cr2 & CR2_EVT) != 0 && ((sr1 & 16'h001F) != 0 ||
			((cr2 & CR2_BUF) != 0 && (sr1 & 16'h00C0) != 0));
		r.err_irq = (cr2 & CR2_ERR) != 0 && (sr1 & 16'hDF00) != 0;
		return r;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		res_t exp_w, got;
		if (!arst_n) begin
			clear_regs();
			expected_words.delete();
			errors <= 0;
		end else begin
			if (push && !full)
				expected_words.push_back(predict_access(cmd, reg_index, write_data,
					slave_ack, rx_byte));
			if (pop && !empty) begin
				got = '{read_data, bus_action, bus_byte, evt_irq, err_irq};
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word %h", $time, got);
					errors <= errors + 1;
				end else begin
					exp_w = expected_words.pop_front();
					if (exp_w != got) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_w, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/i2c_master_register_controller_core_test.sv =====
`timescale 1ns / 1ps
module i2c_master_register_controller_core_test;
	import i2cm_reg_pkg::*;

	logic        clk, arst_n, push, full, cmd, slave_ack, empty, pop;
	logic        evt_irq, err_irq;
	logic [3:0]  reg_index;
	logic [15:0] write_data, read_data;
	logic [7:0]  rx_byte, bus_byte;
	logic [2:0]  bus_action;
	int          errors, pending, idle_cycles, hold_off;
	bit          done, mid_drain;

	i2c_master_register_controller_core DUT (.*);
	i2c_master_register_controller_core_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	task automatic send_access(logic w, logic [3:0] idx, logic [15:0] d, logic a,
			logic [7:0] rx);
		push <= 1'b1; cmd <= w; reg_index <= idx; write_data <= d;
		slave_ack <= a; rx_byte <= rx;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic pause_sender(int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stop offering words and wait until every predicted word has come back
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_access();
		int k;
		k = $urandom_range(0, 99);
		if (k < 12)
			send_access(1'b1, REG_CR1, (16'($urandom) & 16'h7FFF) |
				(($urandom_range(0, 3) == 0) ? 16'h0 : 16'h0001),
				1'($urandom), 8'($urandom));
		else if (k < 40)
			send_access(1'($urandom), REG_DR, 16'($urandom), $urandom_range(0, 5) != 0,
				8'($urandom));
		else if (k < 55)
			send_access(1'b0, $urandom_range(0, 1) ? REG_SR1 : REG_SR2, 16'($urandom),
				1'($urandom), 8'($urandom));
		else if (k < 65)
			send_access(1'b1, REG_CR2, 16'($urandom), 1'($urandom), 8'($urandom));
		else if (k < 67)
			send_access(1'b1, REG_CR1, 16'h8000 | 16'($urandom), 1'($urandom),
				8'($urandom));
		else
			send_access(1'($urandom), 4'($urandom), 16'($urandom), 1'($urandom),
				8'($urandom));
	endtask

	task automatic transfer_sequence();
		logic [7:0] addr;
		addr = 8'($urandom);
		send_access(1'b1, REG_CR1, 16'h0001 | (16'($urandom) & 16'h0400), 1'b0, 8'h00);
		send_access(1'b1, REG_CR1, 16'h0101 | (16'($urandom) & 16'h0400), 1'b0, 8'h00);
		send_access(1'b0, REG_SR1, 16'h0, 1'b0, 8'h00);
		send_access(1'b1, REG_DR, {8'd0, addr}, $urandom_range(0, 7) != 0, 8'h00);
		send_access(1'b0, REG_SR1, 16'h0, 1'b0, 8'h00);
		send_access(1'b0, REG_SR2, 16'h0, 1'b0, 8'h00);
		repeat ($urandom_range(1, 5)) begin
			if (addr[0]) send_access(1'b0, REG_DR, 16'h0, 1'b0, 8'($urandom));
			else send_access(1'b1, REG_DR, 16'($urandom), $urandom_range(0, 5) != 0, 8'h00);
		end
		send_access(1'b1, REG_CR1, 16'h0201, 1'b0, 8'h00);
		if (addr[0]) send_access(1'b0, REG_DR, 16'h0, 1'b0, 8'($urandom));
	endtask

	initial begin
		int n;
		arst_n = 0; push = 0; cmd = 0; reg_index = 0; write_data = 0;
		slave_ack = 0; rx_byte = 0; done = 0; mid_drain = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: disabled CR1 writes, enable, start, address nack, extremes
		send_access(1'b1, REG_CR1, 16'h0F00, 1'b1, 8'h00);
		send_access(1'b1, REG_CR2, 16'hFFFF, 1'b1, 8'h00);
		send_access(1'b1, REG_CR1, 16'h0001, 1'b1, 8'h00);
		send_access(1'b1, REG_CR1, 16'h0101, 1'b1, 8'h00);
		send_access(1'b1, REG_DR, 16'hFFA4, 1'b0, 8'h00);
		send_access(1'b1, REG_DR, 16'h00A4, 1'b1, 8'h00);
		send_access(1'b1, REG_DR, 16'h55FF, 1'b0, 8'hFF);
		send_access(1'b1, REG_DR, 16'h0000, 1'b1, 8'h00);
		send_access(1'b1, REG_CR1, 16'h0201, 1'b1, 8'h00);
		send_access(1'b1, REG_SR1, 16'hFFFF, 1'b1, 8'hFF);
		send_access(1'b1, REG_SR2, 16'hFFFF, 1'b1, 8'hFF);
		send_access(1'b1, REG_TRISE, 16'hFFFF, 1'b1, 8'hFF);
		send_access(1'b1, REG_FLTR, 16'hFFFF, 1'b1, 8'hFF);
		send_access(1'b1, REG_CCR, 16'hFFFF, 1'b1, 8'hFF);
		send_access(1'b1, REG_OAR1, 16'hFFFF, 1'b1, 8'hFF);
		send_access(1'b1, REG_OAR2, 16'hFFFF, 1'b1, 8'hFF);
		send_access(1'b1, 4'hF, 16'hFFFF, 1'b1, 8'hFF);
		for (int i = 0; i < 16; i++) send_access(1'b0, 4'(i), 16'h0, 1'b0, 8'h0);
		send_access(1'b1, REG_CR1, 16'h8000, 1'b1, 8'h00);
		n = 0;
		while (n < 2000) begin
			repeat ($urandom_range(1, 30)) begin
				if ($urandom_range(0, 2) == 0) begin
					transfer_sequence();
					n += 10;
				end else begin
					random_access();
					n++;
				end
			end
			if (!mid_drain && n > 1000) begin
				mid_drain = 1;
				drain();
			end else if ($urandom_range(0, 1)) pause_sender($urandom_range(1, 8));
		end
		drain();
		repeat (10) @(posedge clk);
		done = 1;
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	// receiver: stall pattern, one long hold-off early on
	initial begin
		pop = 0;
		@(posedge arst_n);
		repeat (60) @(posedge clk);
		hold_off = 0;
		while (hold_off < 200) begin
			pop <= 1'b0;
			@(posedge clk);
			hold_off++;
		end
		forever begin
			case ($urandom_range(0, 3))
				0: pop <= 1'b0;
				1: pop <= 1'($urandom_range(0, 1));
				default: pop <= 1'b1;
			endcase
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (arst_n && !done && idle_cycles > 5000) begin
			$display("tb: failure");
			$finish;
		end
	end
endmodule

// ===== sim.f =====
+incdir+design
design/i2cm_reg_pkg.sv
design/i2cm_reg_front.sv
design/i2cm_reg_back.sv
design/i2c_master_register_controller_core.sv
design/i2cm_reg_checker.sv
tb/i2c_master_register_controller_core_checker.sv
tb/i2c_master_register_controller_core_test.sv
